>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked property checks, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ASSERT_CLK_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_CLK_NORST(label, clk, prop)
`endif
`endif

>>> hw/rtl/abspl_pkg.sv
// ---------------------------------------------------------------------------
// A/B slot boot planner package
// Record, result and configuration types, status and mode codes.
// ---------------------------------------------------------------------------
package abspl_pkg;

   localparam logic [2:0] ST_INVALID   = 3'd0;
   localparam logic [2:0] ST_UPDATING  = 3'd1;
   localparam logic [2:0] ST_UPDATED   = 3'd2;
   localparam logic [2:0] ST_TRIAL     = 3'd3;
   localparam logic [2:0] ST_CONFIRMED = 3'd4;

   localparam logic [1:0] MODE_BOOT    = 2'd0;
   localparam logic [1:0] MODE_CONFIRM = 2'd1;
   localparam logic [1:0] MODE_VERSION = 2'd2;

   localparam logic CSR_EXPECTED_MAGIC = 1'b0;
   localparam logic CSR_TRIAL_LIMIT    = 1'b1;

   localparam logic signed [1:0] BOOT_SAFE = -2'sd1;

   localparam logic [7:0] TRIAL_LIMIT_RESET = 8'd3;

   typedef struct packed {
      logic [31:0] expected_magic;
      logic [7:0]  trial_limit;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] magic;
      logic        cand_slot;
      logic [2:0]  a_state;
      logic [2:0]  b_state;
      logic [31:0] trial_cnt;
      logic [31:0] rec_seq;
      logic [31:0] a_ver;
      logic [31:0] b_ver;
      logic        running_slot;
      logic [31:0] offer_ver;
   } req_type;

   typedef struct packed {
      logic signed [1:0] start_slot;
      logic              write_back;
      logic              version_ok;
      logic              new_cand_slot;
      logic [2:0]        new_a_state;
      logic [2:0]        new_b_state;
      logic [31:0]       new_trial_cnt;
      logic [31:0]       new_rec_seq;
   } rsp_type;

endpackage

>>> hw/rtl/abspl_decide.sv
// ---------------------------------------------------------------------------
// A/B slot boot planner decision logic
// Boot plan, confirm and version check on one registered record.
// ---------------------------------------------------------------------------
module abspl_decide (
   input  abspl_pkg::cfg_type cfg,
   input  abspl_pkg::req_type req,
   output abspl_pkg::rsp_type rsp
);

   logic        magic_ok;
   logic        other_slot;
   logic [2:0]  cand_st;
   logic [2:0]  other_st;
   logic [2:0]  run_st;
   logic [31:0] seq_inc;
   logic [31:0] cnt_inc;
   logic        limit_hit;
   logic [31:0] base_a;
   logic [31:0] base;

   assign magic_ok   = (req.magic == cfg.expected_magic);
   assign other_slot = ~req.cand_slot;
   assign cand_st    = req.cand_slot ? req.b_state : req.a_state;
   assign other_st   = other_slot ? req.b_state : req.a_state;
   assign run_st     = req.running_slot ? req.b_state : req.a_state;
   assign seq_inc    = req.rec_seq + 32'd1;
   assign cnt_inc    = req.trial_cnt + 32'd1;
   assign limit_hit  = (req.trial_cnt >= {24'd0, cfg.trial_limit});
   assign base_a     = (req.a_state == abspl_pkg::ST_CONFIRMED) ? req.a_ver : 32'd0;
   assign base       = ((req.b_state == abspl_pkg::ST_CONFIRMED) &&
                        (req.b_ver > base_a)) ? req.b_ver : base_a;

   always_comb begin
      rsp.start_slot    = abspl_pkg::BOOT_SAFE;
      rsp.write_back    = 1'b0;
      rsp.version_ok    = 1'b0;
      rsp.new_cand_slot = req.cand_slot;
      rsp.new_a_state   = req.a_state;
      rsp.new_b_state   = req.b_state;
      rsp.new_trial_cnt = req.trial_cnt;
      rsp.new_rec_seq   = req.rec_seq;
      unique case (req.mode)
         abspl_pkg::MODE_BOOT: begin
            if (!magic_ok) begin
               rsp.start_slot = 2'sd0;
            end else if (cand_st == abspl_pkg::ST_CONFIRMED) begin
               rsp.start_slot = {1'b0, req.cand_slot};
            end else if (cand_st == abspl_pkg::ST_UPDATED) begin
               if (req.cand_slot) rsp.new_b_state = abspl_pkg::ST_TRIAL;
               else rsp.new_a_state = abspl_pkg::ST_TRIAL;
               rsp.new_trial_cnt = 32'd1;
               rsp.new_rec_seq   = seq_inc;
               rsp.write_back    = 1'b1;
               rsp.start_slot    = {1'b0, req.cand_slot};
            end else if (cand_st == abspl_pkg::ST_TRIAL) begin
               rsp.new_rec_seq = seq_inc;
               rsp.write_back  = 1'b1;
               if (limit_hit) begin
                  if (req.cand_slot) rsp.new_b_state = abspl_pkg::ST_INVALID;
                  else rsp.new_a_state = abspl_pkg::ST_INVALID;
                  if (other_st == abspl_pkg::ST_CONFIRMED) begin
                     rsp.new_cand_slot = other_slot;
                     rsp.start_slot    = {1'b0, other_slot};
                  end
               end else begin
                  rsp.new_trial_cnt = cnt_inc;
                  rsp.start_slot    = {1'b0, req.cand_slot};
               end
            end else if (other_st == abspl_pkg::ST_CONFIRMED) begin
               rsp.start_slot = {1'b0, other_slot};
            end
         end
         abspl_pkg::MODE_CONFIRM: begin
            if (magic_ok && ((run_st == abspl_pkg::ST_TRIAL) ||
                             (run_st == abspl_pkg::ST_UPDATED))) begin
               if (req.running_slot) rsp.new_b_state = abspl_pkg::ST_CONFIRMED;
               else rsp.new_a_state = abspl_pkg::ST_CONFIRMED;
               rsp.new_trial_cnt = 32'd0;
               rsp.new_rec_seq   = seq_inc;
               rsp.write_back    = 1'b1;
            end
         end
         abspl_pkg::MODE_VERSION: begin
            rsp.version_ok = (req.offer_ver >= base);
         end
         default: begin
         end
      endcase
   end

endmodule

>>> hw/rtl/ab_slot_boot_planner_unit.sv
// ---------------------------------------------------------------------------
// A/B slot boot planner unit
// Plans the boot slot, confirms trials and checks versions on A/B records.
// Stages: input register, decision logic, result register.
// Throughput: one beat per cycle; busy is always low, the receiver cannot stall.
// Reset: synchronous, clears the valid pipeline and loads magic 0, attempts 3.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ab_slot_boot_planner_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_mode,
   input  logic [31:0]       req_magic,
   input  logic              req_cand_slot,
   input  logic [2:0]        req_a_state,
   input  logic [2:0]        req_b_state,
   input  logic [31:0]       req_trial_cnt,
   input  logic [31:0]       req_rec_seq,
   input  logic [31:0]       req_a_ver,
   input  logic [31:0]       req_b_ver,
   input  logic              req_running_slot,
   input  logic [31:0]       req_offer_ver,
   output logic              rsp_strobe,
   output logic signed [1:0] rsp_start_slot,
   output logic              rsp_write_back,
   output logic              rsp_version_ok,
   output logic              rsp_new_cand_slot,
   output logic [2:0]        rsp_new_a_state,
   output logic [2:0]        rsp_new_b_state,
   output logic [31:0]       rsp_new_trial_cnt,
   output logic [31:0]       rsp_new_rec_seq,
   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [31:0]       csr_wdata
);

   abspl_pkg::cfg_type cfg_ff;
   abspl_pkg::req_type req_ff;
   abspl_pkg::req_type req_in;
   abspl_pkg::rsp_type rsp_ff;
   abspl_pkg::rsp_type rsp_in;
   logic               req_valid_ff;
   logic               rsp_valid_ff;

   assign busy = 1'b0;

   assign req_in.mode         = req_mode;
   assign req_in.magic        = req_magic;
   assign req_in.cand_slot    = req_cand_slot;
   assign req_in.a_state      = req_a_state;
   assign req_in.b_state      = req_b_state;
   assign req_in.trial_cnt    = req_trial_cnt;
   assign req_in.rec_seq      = req_rec_seq;
   assign req_in.a_ver        = req_a_ver;
   assign req_in.b_ver        = req_b_ver;
   assign req_in.running_slot = req_running_slot;
   assign req_in.offer_ver    = req_offer_ver;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_magic <= 32'd0;
         cfg_ff.trial_limit    <= abspl_pkg::TRIAL_LIMIT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            abspl_pkg::CSR_EXPECTED_MAGIC: cfg_ff.expected_magic <= csr_wdata;
            abspl_pkg::CSR_TRIAL_LIMIT:    cfg_ff.trial_limit    <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   abspl_decide u_decide (
      .cfg (cfg_ff),
      .req (req_ff),
      .rsp (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) req_ff <= req_in;
      if (req_valid_ff) rsp_ff <= rsp_in;
   end

   assign rsp_strobe        = rsp_valid_ff;
   assign rsp_start_slot    = rsp_ff.start_slot;
   assign rsp_write_back    = rsp_ff.write_back;
   assign rsp_version_ok    = rsp_ff.version_ok;
   assign rsp_new_cand_slot = rsp_ff.new_cand_slot;
   assign rsp_new_a_state   = rsp_ff.new_a_state;
   assign rsp_new_b_state   = rsp_ff.new_b_state;
   assign rsp_new_trial_cnt = rsp_ff.new_trial_cnt;
   assign rsp_new_rec_seq   = rsp_ff.new_rec_seq;

   `ASSERT_CLK(a_beat_follows_start, clock, reset, (start && !busy) |=> ##1 rsp_strobe)
   `ASSERT_CLK(a_version_only_check, clock, reset, (rsp_strobe && rsp_version_ok) |-> (!rsp_write_back && (rsp_start_slot == abspl_pkg::BOOT_SAFE)))
   `ASSERT_CLK(a_seq_bumped, clock, reset, (rsp_strobe && rsp_write_back) |-> (rsp_new_rec_seq == ($past(req_rec_seq, 2) + 32'd1)))

endmodule

>>> bench/ab_slot_boot_planner_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// A/B slot boot planner unit testbench
// Sends metadata records in boot, confirm, version and reserved modes, first
// a hand-picked set at reset configuration, then shaped random records over
// several magic and attempt-limit settings. Each record's plan is predicted
// here and compared field by field with the result beat.
// ---------------------------------------------------------------------------
module ab_slot_boot_planner_unit_tb;

   localparam logic [1:0] MODE_NOP = 2'd3;
   localparam int PIPE_LATENCY = 2;
   localparam int STALL_LIMIT  = 500;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   abspl_pkg::req_type req_beat = '0;
   logic               rsp_strobe;
   logic signed [1:0]  rsp_start_slot;
   logic               rsp_write_back;
   logic               rsp_version_ok;
   logic               rsp_new_cand_slot;
   logic [2:0]         rsp_new_a_state;
   logic [2:0]         rsp_new_b_state;
   logic [31:0]        rsp_new_trial_cnt;
   logic [31:0]        rsp_new_rec_seq;
   logic               csr_wr_en = 1'b0;
   logic               csr_index = abspl_pkg::CSR_EXPECTED_MAGIC;
   logic [31:0]        csr_wdata = '0;

   logic [31:0]        magic_cfg = '0;
   logic [7:0]         attempts_cfg = abspl_pkg::TRIAL_LIMIT_RESET;
   abspl_pkg::rsp_type plan_q[$];
   abspl_pkg::rsp_type want_plan;
   int                 mismatch_count = 0;
   int                 stalled_cycles = 0;
   bit                 steady_send = 1'b0;

   ab_slot_boot_planner_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_beat.mode),
      .req_magic        (req_beat.magic),
      .req_cand_slot    (req_beat.cand_slot),
      .req_a_state      (req_beat.a_state),
      .req_b_state      (req_beat.b_state),
      .req_trial_cnt    (req_beat.trial_cnt),
      .req_rec_seq      (req_beat.rec_seq),
      .req_a_ver        (req_beat.a_ver),
      .req_b_ver        (req_beat.b_ver),
      .req_running_slot (req_beat.running_slot),
      .req_offer_ver    (req_beat.offer_ver),
      .rsp_strobe       (rsp_strobe),
      .rsp_start_slot   (rsp_start_slot),
      .rsp_write_back   (rsp_write_back),
      .rsp_version_ok   (rsp_version_ok),
      .rsp_new_cand_slot(rsp_new_cand_slot),
      .rsp_new_a_state  (rsp_new_a_state),
      .rsp_new_b_state  (rsp_new_b_state),
      .rsp_new_trial_cnt(rsp_new_trial_cnt),
      .rsp_new_rec_seq  (rsp_new_rec_seq),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic abspl_pkg::rsp_type with_status(input abspl_pkg::rsp_type p,
                                                      input logic slot,
                                                      input logic [2:0] status);
      if (slot) p.new_b_state = status;
      else p.new_a_state = status;
      return p;
   endfunction

   function automatic abspl_pkg::rsp_type plan_record(input abspl_pkg::req_type r);
      abspl_pkg::rsp_type p;
      logic               cand;
      logic               other;
      logic [2:0]         cand_st;
      logic [2:0]         other_st;
      logic [2:0]         run_st;
      logic [31:0]        baseline;
      p.start_slot    = abspl_pkg::BOOT_SAFE;
      p.write_back    = 1'b0;
      p.version_ok    = 1'b0;
      p.new_cand_slot = r.cand_slot;
      p.new_a_state   = r.a_state;
      p.new_b_state   = r.b_state;
      p.new_trial_cnt = r.trial_cnt;
      p.new_rec_seq   = r.rec_seq;
      cand     = r.cand_slot;
      other    = ~r.cand_slot;
      cand_st  = cand ? r.b_state : r.a_state;
      other_st = cand ? r.a_state : r.b_state;
      run_st   = r.running_slot ? r.b_state : r.a_state;
      unique case (r.mode)
         abspl_pkg::MODE_BOOT: begin
            if (r.magic != magic_cfg) begin
               p.start_slot = 2'sd0;
            end else if (cand_st == abspl_pkg::ST_CONFIRMED) begin
               p.start_slot = {1'b0, cand};
            end else if (cand_st == abspl_pkg::ST_UPDATED) begin
               p = with_status(p, cand, abspl_pkg::ST_TRIAL);
               p.new_trial_cnt = 32'd1;
               p.new_rec_seq   = r.rec_seq + 32'd1;
               p.write_back    = 1'b1;
               p.start_slot    = {1'b0, cand};
            end else if (cand_st == abspl_pkg::ST_TRIAL) begin
               p.new_rec_seq = r.rec_seq + 32'd1;
               p.write_back  = 1'b1;
               if (r.trial_cnt >= {24'd0, attempts_cfg}) begin
                  p = with_status(p, cand, abspl_pkg::ST_INVALID);
                  if (other_st == abspl_pkg::ST_CONFIRMED) begin
                     p.new_cand_slot = other;
                     p.start_slot    = {1'b0, other};
                  end
               end else begin
                  p.new_trial_cnt = r.trial_cnt + 32'd1;
                  p.start_slot    = {1'b0, cand};
               end
            end else if (other_st == abspl_pkg::ST_CONFIRMED) begin
               p.start_slot = {1'b0, other};
            end
         end
         abspl_pkg::MODE_CONFIRM: begin
            if (r.magic == magic_cfg &&
                (run_st == abspl_pkg::ST_TRIAL || run_st == abspl_pkg::ST_UPDATED)) begin
               p = with_status(p, r.running_slot, abspl_pkg::ST_CONFIRMED);
               p.new_trial_cnt = '0;
               p.new_rec_seq   = r.rec_seq + 32'd1;
               p.write_back    = 1'b1;
            end
         end
         abspl_pkg::MODE_VERSION: begin
            baseline = '0;
            if (r.a_state == abspl_pkg::ST_CONFIRMED && r.a_ver > baseline)
               baseline = r.a_ver;
            if (r.b_state == abspl_pkg::ST_CONFIRMED && r.b_ver > baseline)
               baseline = r.b_ver;
            p.version_ok = (r.offer_ver >= baseline);
         end
         default: ;
      endcase
      return p;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want_v,
                                       input logic [31:0] got_v);
      if (got_v !== want_v) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch %s: expected %h, got %h", name, want_v, got_v);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (plan_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("result beat with no record pending");
         end else begin
            want_plan = plan_q.pop_front();
            check_field("start_slot", want_plan.start_slot, rsp_start_slot);
            check_field("write_back", want_plan.write_back, rsp_write_back);
            check_field("version_ok", want_plan.version_ok, rsp_version_ok);
            check_field("new_cand_slot", want_plan.new_cand_slot, rsp_new_cand_slot);
            check_field("new_a_state", want_plan.new_a_state, rsp_new_a_state);
            check_field("new_b_state", want_plan.new_b_state, rsp_new_b_state);
            check_field("new_trial_cnt", want_plan.new_trial_cnt, rsp_new_trial_cnt);
            check_field("new_rec_seq", want_plan.new_rec_seq, rsp_new_rec_seq);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) stalled_cycles <= 0;
      else stalled_cycles <= stalled_cycles + 1;
   end

   initial begin
      wait (stalled_cycles >= STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   // call at a falling edge; returns at a falling edge
   task automatic send_beat(input abspl_pkg::req_type r);
      while (!steady_send && $urandom_range(0, 99) < 19) begin
         start <= 1'b0;
         @(posedge clock);
         @(negedge clock);
      end
      req_beat <= r;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      plan_q.push_back(plan_record(r));
      @(negedge clock);
   endtask

   task automatic settle();
      start <= 1'b0;
      while (plan_q.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic apply_config(input logic [31:0] magic_value, input logic [7:0] attempts_value);
      csr_wr_en <= 1'b1;
      csr_index <= abspl_pkg::CSR_EXPECTED_MAGIC;
      csr_wdata <= magic_value;
      @(posedge clock);
      magic_cfg = magic_value;
      @(negedge clock);
      csr_index <= abspl_pkg::CSR_TRIAL_LIMIT;
      // upper bits are don't-care for the attempt limit
      csr_wdata <= {24'($urandom), attempts_value};
      @(posedge clock);
      attempts_cfg = attempts_value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic abspl_pkg::req_type base_record(input logic [1:0] mode);
      abspl_pkg::req_type r;
      r.mode         = mode;
      r.magic        = magic_cfg;
      r.cand_slot    = 1'b0;
      r.a_state      = abspl_pkg::ST_INVALID;
      r.b_state      = abspl_pkg::ST_INVALID;
      r.trial_cnt    = '0;
      r.rec_seq      = $urandom;
      r.a_ver        = $urandom;
      r.b_ver        = $urandom;
      r.running_slot = 1'($urandom_range(0, 1));
      r.offer_ver    = $urandom;
      return r;
   endfunction

   function automatic logic [2:0] random_status();
      if ($urandom_range(0, 9) != 0)
         return 3'($urandom_range(abspl_pkg::ST_INVALID, abspl_pkg::ST_CONFIRMED));
      return 3'($urandom_range(abspl_pkg::ST_CONFIRMED + 1, 7));
   endfunction

   function automatic logic [31:0] random_version();
      if ($urandom_range(0, 1) != 0) return $urandom_range(0, 15);
      return $urandom;
   endfunction

   function automatic abspl_pkg::req_type random_record();
      abspl_pkg::req_type r;
      int unsigned        pick;
      r.mode         = 2'($urandom_range(0, 3));
      r.magic        = $urandom;
      r.cand_slot    = 1'($urandom_range(0, 1));
      r.a_state      = 3'($urandom_range(0, 7));
      r.b_state      = 3'($urandom_range(0, 7));
      r.trial_cnt    = $urandom;
      r.rec_seq      = $urandom;
      r.a_ver        = $urandom;
      r.b_ver        = $urandom;
      r.running_slot = 1'($urandom_range(0, 1));
      r.offer_ver    = $urandom;
      if ($urandom_range(0, 99) >= 10) begin
         pick = $urandom_range(0, 99);
         r.mode = (pick < 45) ? abspl_pkg::MODE_BOOT :
                  (pick < 70) ? abspl_pkg::MODE_CONFIRM :
                  (pick < 94) ? abspl_pkg::MODE_VERSION : MODE_NOP;
         if ($urandom_range(0, 9) != 0) r.magic = magic_cfg;
         r.a_state = random_status();
         r.b_state = random_status();
         case ($urandom_range(0, 4))
            0: r.trial_cnt = {24'd0, attempts_cfg} - 32'd1;
            1: r.trial_cnt = {24'd0, attempts_cfg};
            2: r.trial_cnt = {24'd0, attempts_cfg} + 32'd1;
            3: r.trial_cnt = $urandom_range(0, 8);
            default: ;
         endcase
         if ($urandom_range(0, 7) == 0) r.rec_seq = '1;
         r.a_ver = random_version();
         r.b_ver = random_version();
         case ($urandom_range(0, 3))
            0: r.offer_ver = r.a_ver;
            1: r.offer_ver = r.b_ver;
            2: r.offer_ver = random_version();
            default: ;
         endcase
      end
      return r;
   endfunction

   task automatic test_boot_plans();
      abspl_pkg::req_type r;
      r = base_record(abspl_pkg::MODE_BOOT);
      r.magic = ~magic_cfg;
      r.a_state = abspl_pkg::ST_TRIAL;
      r.b_state = abspl_pkg::ST_CONFIRMED;
      r.cand_slot = 1'b1;
      send_beat(r);
      r = base_record(abspl_pkg::MODE_BOOT);
      r.a_state = abspl_pkg::ST_CONFIRMED;
      send_beat(r);
      r = base_record(abspl_pkg::MODE_BOOT);
      r.cand_slot = 1'b1;
      r.b_state = abspl_pkg::ST_UPDATED;
      r.rec_seq = '1;
      send_beat(r);
      r = base_record(abspl_pkg::MODE_BOOT);
      r.a_state = abspl_pkg::ST_TRIAL;
      r.trial_cnt = {24'd0, attempts_cfg} - 32'd1;
      send_beat(r);
      r = base_record(abspl_pkg::MODE_BOOT);
      r.cand_slot = 1'b1;
      r.a_state = abspl_pkg::ST_CONFIRMED;
      r.b_state = abspl_pkg::ST_TRIAL;
      r.trial_cnt = {24'd0, attempts_cfg};
      send_beat(r);
      r = base_record(abspl_pkg::MODE_BOOT);
      r.a_state = abspl_pkg::ST_TRIAL;
      r.b_state = abspl_pkg::ST_TRIAL;
      r.trial_cnt = '1;
      send_beat(r);
      r = base_record(abspl_pkg::MODE_BOOT);
      r.b_state = abspl_pkg::ST_CONFIRMED;
      send_beat(r);
      r = base_record(abspl_pkg::MODE_BOOT);
      r.cand_slot = 1'b1;
      r.a_state = abspl_pkg::ST_UPDATED;
      r.b_state = abspl_pkg::ST_UPDATING;
      send_beat(r);
      r = base_record(abspl_pkg::MODE_BOOT);
      r.a_state = 3'd7;
      r.b_state = abspl_pkg::ST_CONFIRMED;
      send_beat(r);
      r = base_record(abspl_pkg::MODE_BOOT);
      r.cand_slot = 1'b1;
      r.b_state = 3'd5;
      send_beat(r);
   endtask

   task automatic test_confirms();
      abspl_pkg::req_type r;
      r = base_record(abspl_pkg::MODE_CONFIRM);
      r.running_slot = 1'b0;
      r.a_state = abspl_pkg::ST_TRIAL;
      r.trial_cnt = '1;
      send_beat(r);
      r = base_record(abspl_pkg::MODE_CONFIRM);
      r.running_slot = 1'b1;
      r.b_state = abspl_pkg::ST_UPDATED;
      r.rec_seq = '1;
      send_beat(r);
      r = base_record(abspl_pkg::MODE_CONFIRM);
      r.running_slot = 1'b0;
      r.a_state = abspl_pkg::ST_CONFIRMED;
      send_beat(r);
      r = base_record(abspl_pkg::MODE_CONFIRM);
      r.magic = ~magic_cfg;
      r.running_slot = 1'b1;
      r.b_state = abspl_pkg::ST_TRIAL;
      send_beat(r);
      r = base_record(abspl_pkg::MODE_CONFIRM);
      r.running_slot = 1'b0;
      r.a_state = 3'd6;
      send_beat(r);
   endtask

   task automatic test_version_checks();
      abspl_pkg::req_type r;
      r = base_record(abspl_pkg::MODE_VERSION);
      r.a_state = abspl_pkg::ST_CONFIRMED;
      r.b_state = abspl_pkg::ST_CONFIRMED;
      r.offer_ver = (r.a_ver > r.b_ver) ? r.a_ver : r.b_ver;
      send_beat(r);
      r = base_record(abspl_pkg::MODE_VERSION);
      r.a_state = abspl_pkg::ST_CONFIRMED;
      r.a_ver = '1;
      r.offer_ver = 32'hFFFF_FFFE;
      send_beat(r);
      r = base_record(abspl_pkg::MODE_VERSION);
      r.a_state = abspl_pkg::ST_TRIAL;
      r.b_state = abspl_pkg::ST_UPDATED;
      r.offer_ver = '0;
      send_beat(r);
      r = base_record(abspl_pkg::MODE_VERSION);
      r.magic = ~magic_cfg;
      r.b_state = abspl_pkg::ST_CONFIRMED;
      r.b_ver = 32'd5;
      r.offer_ver = 32'd4;
      send_beat(r);
   endtask

   task automatic test_reserved_mode();
      abspl_pkg::req_type r;
      r = base_record(MODE_NOP);
      r.a_state = abspl_pkg::ST_TRIAL;
      r.b_state = abspl_pkg::ST_CONFIRMED;
      r.trial_cnt = '1;
      send_beat(r);
      r = base_record(MODE_NOP);
      r.cand_slot = 1'b1;
      r.b_state = abspl_pkg::ST_UPDATED;
      send_beat(r);
   endtask

   task automatic test_random_records(input logic [31:0] magic_value,
                                      input logic [7:0] attempts_value,
                                      input int count, input bit no_gaps);
      settle();
      apply_config(magic_value, attempts_value);
      steady_send = no_gaps;
      repeat (count) send_beat(random_record());
      steady_send = 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_boot_plans();
      test_confirms();
      test_version_checks();
      test_reserved_mode();
      test_random_records($urandom, 8'd3, 235, 1'b0);
      test_random_records('1, 8'd0, 235, 1'b0);
      test_random_records('0, 8'hFF, 235, 1'b0);
      test_random_records($urandom, 8'd1, 235, 1'b1);
      test_random_records($urandom, 8'($urandom), 235, 1'b0);
      test_random_records($urandom, 8'd2, 235, 1'b0);
      settle();
      if (mismatch_count == 0 && plan_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
